>>> sv/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and constants for the first-fit block allocator
// Request kinds, status codes, widths and the descriptor cell bus types.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int unsigned MAX_BLOCKS   = 64;
	localparam int unsigned HEADER_BYTES = 32;
	localparam int unsigned IDX_W        = $clog2(MAX_BLOCKS);
	localparam int unsigned CNT_W        = $clog2(MAX_BLOCKS + 1);
	localparam int unsigned SIZE_W       = 27;
	localparam int unsigned ADDR_W       = 32;
	localparam int unsigned CFG_W        = 32;

	localparam logic [1:0] KIND_ALLOC   = 2'd0;
	localparam logic [1:0] KIND_FREE    = 2'd1;
	localparam logic [1:0] KIND_REALLOC = 2'd2;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_SIZE   = 3'd1;
	localparam logic [2:0] ST_EXHAUSTED  = 3'd2;
	localparam logic [2:0] ST_TABLE_FULL = 3'd3;
	localparam logic [2:0] ST_BAD_ADDR   = 3'd4;

	localparam logic CFG_HEAP_LIMIT  = 1'b0;
	localparam logic CFG_MAX_REQUEST = 1'b1;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] start;
		logic [SIZE_W-1:0] size;
		logic              free;
	} ffba_desc_t;

	typedef struct packed {
		logic              load;
		logic [IDX_W-1:0]  idx;
		logic [ADDR_W-1:0] start;
		logic [SIZE_W-1:0] size;
		logic              set_free;
		logic [IDX_W-1:0]  free_idx;
		logic [IDX_W-1:0]  take_idx;
		logic              take;
	} ffba_wr_t;

endpackage

>>> sv/ffba_if.sv
// ----------------------------------------------------------------------------
// ffba_req_if / ffba_rsp_if: request and response channels
// Valid/ready channels carrying allocator transactions.
// ----------------------------------------------------------------------------
interface ffba_req_if;
	import ffba_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic [31:0]       request_size;
	logic [31:0]       payload_address;
	modport source (output valid, kind, request_size, payload_address, input ready);
	modport sink (input valid, kind, request_size, payload_address, output ready);
endinterface

interface ffba_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] result_address;
	logic [26:0] copy_bytes;
	logic [6:0]  free_block_count;
	logic [31:0] free_byte_count;
	logic [6:0]  block_count;
	logic [31:0] block_byte_count;
	logic [31:0] header_byte_count;
	modport source (output valid, status, result_address, copy_bytes, free_block_count,
		free_byte_count, block_count, block_byte_count, header_byte_count, input ready);
	modport sink (input valid, status, result_address, copy_bytes, free_block_count,
		free_byte_count, block_count, block_byte_count, header_byte_count, output ready);
endinterface

>>> sv/ffba_cell.sv
// ----------------------------------------------------------------------------
// ffba_cell: one block descriptor in the scan chain
// Holds a descriptor; shifts copies toward the scan tap each cycle on rotate.
// ----------------------------------------------------------------------------
module ffba_cell
	import ffba_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] my_idx,
	input  logic             rotate,
	input  ffba_wr_t         wr,
	input  ffba_desc_t       nbr,
	output ffba_desc_t       tap
);

	logic              valid_q;
	logic [ADDR_W-1:0] start_q;
	logic [SIZE_W-1:0] size_q;
	logic              free_q;
	ffba_desc_t        tap_q;
	ffba_desc_t        own;

	assign own = {valid_q, start_q, size_q, free_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr.load && wr.idx == my_idx) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.load && wr.idx == my_idx) begin
			start_q <= wr.start;
			size_q  <= wr.size;
			free_q  <= 1'b0;
		end else begin
			if (wr.set_free && wr.free_idx == my_idx)
				free_q <= 1'b1;
			if (wr.take && wr.take_idx == my_idx)
				free_q <= 1'b0;
		end
		if (rotate)
			tap_q <= nbr;
		else
			tap_q <= own;
	end

	assign tap = tap_q;

endmodule

>>> sv/first_fit_block_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core: first-fit heap allocator, no splitting
// For each request the descriptor chain is loaded into a shift line and
// walked one cell per cycle past a single compare tap, looking both for the
// live block at the given address and for the first free block large
// enough; the DONE state then commits the update and registers the result.
// Results sit in an output register; the next request is taken only once
// the waiting result drains, at the earliest in the same cycle as the drain.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_core
	import ffba_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata,
	ffba_req_if.sink          req,
	ffba_rsp_if.source        rsp
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t            state_q;
	logic [31:0]       heap_limit_q;
	logic [SIZE_W-1:0] max_request_q;
	logic [1:0]        kind_q;
	logic [31:0]       size_q;
	logic [31:0]       paddr_q;
	logic [CNT_W-1:0]  used_q;
	logic [31:0]       heap_top_q;
	logic [CNT_W-1:0]  free_blocks_q;
	logic [31:0]       free_bytes_q;
	logic [31:0]       total_bytes_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              fit_hit_q;
	logic [IDX_W-1:0]  fit_idx_q;
	logic [SIZE_W-1:0] fit_size_q;
	logic [ADDR_W-1:0] fit_start_q;
	logic              live_hit_q;
	logic              addr_seen_q;
	logic [IDX_W-1:0]  live_idx_q;
	logic [SIZE_W-1:0] live_size_q;
	logic              out_valid_q;

	ffba_wr_t   wr;
	ffba_desc_t taps [MAX_BLOCKS];
	logic       rotate;

	assign rotate = (state_q == S_SCAN);

	for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
		ffba_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.my_idx (IDX_W'(g)),
			.rotate (rotate),
			.wr     (wr),
			.nbr    ((g == MAX_BLOCKS - 1) ? taps[0] : taps[(g + 1) % MAX_BLOCKS]),
			.tap    (taps[g])
		);
	end

	// scan tap: cell 0 holds descriptor cnt_q during scan
	ffba_desc_t       cur;
	logic [IDX_W-1:0] cur_idx;
	logic [32:0]      cur_pay;
	assign cur     = taps[0];
	assign cur_idx = cnt_q[IDX_W-1:0];
	assign cur_pay = {1'b0, cur.start} + 33'(HEADER_BYTES);

	logic size_bad;
	assign size_bad = (size_q == 32'd0) || (size_q > {5'd0, max_request_q});

	// commit decision
	logic              need_alloc;
	logic              do_free_old;
	logic [2:0]        st;
	logic [31:0]       raddr;
	logic [SIZE_W-1:0] copy;
	logic              new_ok;
	logic [33:0]       heap_end;
	logic              keep;

	assign heap_end = {2'd0, heap_top_q} + {2'd0, size_q} + 34'(HEADER_BYTES);

	always_comb begin
		need_alloc  = 1'b0;
		do_free_old = 1'b0;
		st          = ST_OK;
		keep        = 1'b0;
		unique case (kind_q)
			KIND_ALLOC: begin
				if (size_bad) st = ST_BAD_SIZE;
				else need_alloc = 1'b1;
			end
			KIND_FREE: begin
				if (paddr_q != 32'd0) begin
					if (!live_hit_q) st = ST_BAD_ADDR;
					else do_free_old = 1'b1;
				end
			end
			KIND_REALLOC: begin
				if (size_bad) st = ST_BAD_SIZE;
				else if (paddr_q == 32'd0) need_alloc = 1'b1;
				else if (!live_hit_q) st = ST_BAD_ADDR;
				else if ({5'd0, live_size_q} >= size_q) keep = 1'b1;
				else need_alloc = 1'b1;
			end
			default: ;
		endcase
		new_ok = 1'b0;
		raddr  = 32'd0;
		copy   = '0;
		if (need_alloc) begin
			priority if (fit_hit_q) begin
				raddr = fit_start_q + 32'(HEADER_BYTES);
			end else if (used_q >= CNT_W'(MAX_BLOCKS)) begin
				st = ST_TABLE_FULL;
			end else if (heap_end > {2'd0, heap_limit_q}) begin
				st = ST_EXHAUSTED;
			end else begin
				new_ok = 1'b1;
				raddr  = heap_top_q + 32'(HEADER_BYTES);
			end
			if (st == ST_OK && kind_q == KIND_REALLOC && paddr_q != 32'd0) begin
				do_free_old = 1'b1;
				copy        = live_size_q;
			end
		end
		if (keep) raddr = paddr_q;
	end

	logic commit;
	assign commit = (state_q == S_DONE);

	always_comb begin
		wr          = '0;
		wr.load     = commit && new_ok;
		wr.idx      = used_q[IDX_W-1:0];
		wr.start    = heap_top_q;
		wr.size     = size_q[SIZE_W-1:0];
		wr.take     = commit && need_alloc && fit_hit_q;
		wr.take_idx = fit_idx_q;
		wr.set_free = commit && do_free_old;
		wr.free_idx = live_idx_q;
	end

	assign req.ready = (state_q == S_IDLE) && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			heap_limit_q  <= 32'hFFFF_FFFF;
			max_request_q <= SIZE_W'(100000000);
			used_q        <= '0;
			heap_top_q    <= '0;
			free_blocks_q <= '0;
			free_bytes_q  <= '0;
			total_bytes_q <= '0;
			cnt_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_HEAP_LIMIT:  heap_limit_q  <= cfg_wdata;
					CFG_MAX_REQUEST: max_request_q <= cfg_wdata[SIZE_W-1:0];
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						state_q <= S_SCAN;
						cnt_q   <= '0;
					end
				end
				S_SCAN: begin
					if (cnt_q == CNT_W'(MAX_BLOCKS)) state_q <= S_DONE;
					cnt_q <= cnt_q + CNT_W'(1);
				end
				S_DONE: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b1;
					if (new_ok) begin
						used_q        <= used_q + CNT_W'(1);
						heap_top_q    <= heap_end[31:0];
						total_bytes_q <= total_bytes_q + size_q;
					end
					free_blocks_q <= free_blocks_q
						- CNT_W'(wr.take) + CNT_W'(do_free_old);
					free_bytes_q <= free_bytes_q
						- (wr.take ? {5'd0, fit_size_q} : 32'd0)
						+ (do_free_old ? {5'd0, live_size_q} : 32'd0);
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// scan payload capture and response registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid && req.ready) begin
			kind_q      <= req.kind;
			size_q      <= req.request_size;
			paddr_q     <= req.payload_address;
			fit_hit_q   <= 1'b0;
			live_hit_q  <= 1'b0;
			addr_seen_q <= 1'b0;
		end else if (state_q == S_SCAN && cnt_q < used_q && cur.valid) begin
			if (!fit_hit_q && cur.free && {5'd0, cur.size} >= size_q) begin
				fit_hit_q   <= 1'b1;
				fit_idx_q   <= cur_idx;
				fit_size_q  <= cur.size;
				fit_start_q <= cur.start;
			end
			if (!addr_seen_q && cur_pay == {1'b0, paddr_q}) begin
				addr_seen_q <= 1'b1;
				live_hit_q  <= !cur.free;
				live_idx_q  <= cur_idx;
				live_size_q <= cur.size;
			end
		end
		if (commit) begin
			rsp.status            <= st;
			rsp.result_address    <= raddr;
			rsp.copy_bytes        <= copy;
			rsp.free_block_count  <= 7'(free_blocks_q - CNT_W'(wr.take) + CNT_W'(do_free_old));
			rsp.free_byte_count   <= free_bytes_q
				- (wr.take ? {5'd0, fit_size_q} : 32'd0)
				+ (do_free_old ? {5'd0, live_size_q} : 32'd0);
			rsp.block_count       <= 7'(used_q + CNT_W'(new_ok));
			rsp.block_byte_count  <= total_bytes_q + (new_ok ? size_q : 32'd0);
			rsp.header_byte_count <= 32'(used_q + CNT_W'(new_ok)) * 32'(HEADER_BYTES);
		end
	end

	assign rsp.valid = out_valid_q;

endmodule
